// ----- hdl/assert_macros.svh -----
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is asserted
`define DFN_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked in the cycle after its trigger
`define DFN_ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

// ----- hdl/dfn_pkg.sv -----
// types, constants and codes shared by the nms filter modules
`default_nettype none
package dfn_pkg;

    localparam int MAX_KEPT = 32;
    localparam int CNT_W    = $clog2(MAX_KEPT + 1);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_KEPT);

    // configuration register indexes
    localparam logic [2:0] CFG_SCORE_THR   = 3'd0;
    localparam logic [2:0] CFG_OVERLAP_THR = 3'd1;
    localparam logic [2:0] CFG_REGION_X    = 3'd2;
    localparam logic [2:0] CFG_REGION_Y    = 3'd3;
    localparam logic [2:0] CFG_REGION_W    = 3'd4;
    localparam logic [2:0] CFG_REGION_H    = 3'd5;
    localparam logic [2:0] CFG_LABELED     = 3'd6;

    localparam logic [7:0] SHARED_CLASS = 8'd255;

    // corner order: 0 left, 1 top, 2 right, 3 bottom
    typedef logic [3:0][15:0] corners_t;

    typedef struct packed {
        corners_t   corners;
        logic [15:0] score;
        logic [7:0]  cls;
    } entry_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NORM_GO,
        S_NORM_WAIT,
        S_SCAN_A,
        S_SCAN_B,
        S_SCAN_C,
        S_SCAN_D,
        S_SHIFT_REST,
        S_APPEND,
        S_FINISH,
        S_EMIT_LIST,
        S_EMIT_NONE
    } state_t;

endpackage
`default_nettype wire

// ----- hdl/detection_filter_greedy_nms_core.sv -----
// top level of the greedy nms detection filter
// a candidate outside the region or under the score threshold skips the divider; an accepted
//   one runs it on each of its 4 corners in turn and then scans the kept list
// throughput: one candidate at a time; frame end then emits one beat per cycle while out_stall is low
// reset: rst_n asynchronous active low; list empty, overflow clear, registers at defaults
// kept list contents are undefined after reset and never read before written
`default_nettype none
module detection_filter_greedy_nms_core
    import dfn_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    // candidate channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [15:0] cand_left,
    input  wire logic [15:0] cand_top,
    input  wire logic [15:0] cand_right,
    input  wire logic [15:0] cand_bottom,
    input  wire logic [15:0] cand_score,
    input  wire logic [7:0]  cand_class,
    input  wire logic        frame_end,
    // result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      box_left,
    output logic [15:0]      box_top,
    output logic [15:0]      box_right,
    output logic [15:0]      box_bottom,
    output logic [15:0]      box_score,
    output logic [7:0]       box_class,
    output logic             box_valid,
    output logic             list_overflow,
    output logic             last_box
);

    `include "assert_macros.svh"

    // configuration registers
    logic [15:0] score_thr_reg, overlap_thr_reg, region_x_reg, region_y_reg;
    logic [15:0] region_w_reg, region_h_reg;
    logic [7:0]  labeled_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_thr_reg   <= 16'd45875;
            overlap_thr_reg <= 16'd32768;
            region_x_reg    <= 16'd0;
            region_y_reg    <= 16'd0;
            region_w_reg    <= 16'd10240;
            region_h_reg    <= 16'd10240;
            labeled_reg     <= 8'd80;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SCORE_THR:   score_thr_reg   <= cfg_data;
                CFG_OVERLAP_THR: overlap_thr_reg <= cfg_data;
                CFG_REGION_X:    region_x_reg    <= cfg_data;
                CFG_REGION_Y:    region_y_reg    <= cfg_data;
                CFG_REGION_W:    region_w_reg    <= cfg_data;
                CFG_REGION_H:    region_h_reg    <= cfg_data;
                CFG_LABELED:     labeled_reg     <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    // control state
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] steps_reg, steps_next;
    logic             ovf_reg, ovf_next;
    logic             disc_reg, disc_next;
    logic             fend_reg;
    logic [1:0]       corner_reg, corner_next;

    // candidate payload
    logic [3:0][15:0] dist_reg;
    corners_t         cand_box_reg;
    logic [15:0]      cand_score_reg;
    logic [7:0]       cand_key_reg;

    // output register
    logic        out_valid_reg;
    entry_t      out_entry_reg;
    logic        out_bvalid_reg, out_ovf_reg, out_last_reg;

    logic in_acc, out_free;
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE);

    // region check on the incoming corners (offset, sign and extent compare) and score threshold
    logic signed [17:0] dl, dt, dr, db;
    logic               ok_l, ok_t, ok_r, ok_b, cand_ok;

    always_comb
    begin
        dl = $signed({{2{cand_left[15]}}, cand_left})     - $signed({2'b00, region_x_reg});
        dt = $signed({{2{cand_top[15]}}, cand_top})       - $signed({2'b00, region_y_reg});
        dr = $signed({{2{cand_right[15]}}, cand_right})   - $signed({2'b00, region_x_reg});
        db = $signed({{2{cand_bottom[15]}}, cand_bottom}) - $signed({2'b00, region_y_reg});
        ok_l = (region_w_reg != 16'd0) && !dl[17] && (dl[16:0] <= {1'b0, region_w_reg});
        ok_t = (region_h_reg != 16'd0) && !dt[17] && (dt[16:0] <= {1'b0, region_h_reg});
        ok_r = (region_w_reg != 16'd0) && !dr[17] && (dr[16:0] <= {1'b0, region_w_reg});
        ok_b = (region_h_reg != 16'd0) && !db[17] && (db[16:0] <= {1'b0, region_h_reg});
        cand_ok = (cand_score >= score_thr_reg) && ok_l && ok_t && ok_r && ok_b;
    end

    // shared divider, one corner at a time; x corners use width, y corners height
    logic        div_start, div_done;
    logic [15:0] div_quo;

    dfn_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (dist_reg[corner_reg]),
        .den   (corner_reg[0] ? region_h_reg : region_w_reg),
        .quo   (div_quo),
        .done  (div_done)
    );

    // the kept list: cell 0 is the head, the overlap unit watches it
    entry_t               cells [MAX_KEPT];
    cell_ctrl_t           cell_ctrl [MAX_KEPT];
    entry_t               tail_entry;
    logic                 rotate_en, drop_en, append_en, pop_en;
    logic [CNT_W-1:0]     tail_pos;
    entry_t               cand_entry;

    assign cand_entry = '{corners: cand_box_reg, score: cand_score_reg, cls: cand_key_reg};
    assign tail_entry = rotate_en ? cells[0] : cand_entry;
    assign tail_pos   = rotate_en ? (cnt_reg - CNT_W'(1)) : cnt_reg;

    for (genvar gi = 0; gi < MAX_KEPT; gi++)
    begin : g_cell
        localparam logic [CNT_W-1:0] IDX = CNT_W'(gi);
        entry_t nbr;

        if (gi == MAX_KEPT - 1)
        begin : g_end
            assign nbr = tail_entry;
        end
        else
        begin : g_mid
            assign nbr = cells[gi + 1];
        end

        assign cell_ctrl[gi].shift = rotate_en || drop_en || pop_en;
        assign cell_ctrl[gi].load  = (rotate_en || append_en) && (tail_pos == IDX);

        dfn_cell u_cell (
            .clk  (clk),
            .ctrl (cell_ctrl[gi]),
            .nbr  (nbr),
            .tail (tail_entry),
            .q    (cells[gi])
        );
    end

    logic iou_hit, match, higher;

    dfn_iou u_iou (
        .clk   (clk),
        .box_a (cand_box_reg),
        .box_b (cells[0].corners),
        .thr   (overlap_thr_reg),
        .hit   (iou_hit)
    );

    assign match  = iou_hit && (cells[0].cls == cand_key_reg);
    assign higher = cand_score_reg > cells[0].score;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = cand_ok ? S_NORM_GO : S_FINISH;
                end
            end
            S_NORM_GO:
            begin
                state_next = S_NORM_WAIT;
            end
            S_NORM_WAIT:
            begin
                if (div_done)
                begin
                    if (corner_reg != 2'd3)
                    begin
                        state_next = S_NORM_GO;
                    end
                    else
                    begin
                        state_next = (cnt_reg == '0) ? S_APPEND : S_SCAN_A;
                    end
                end
            end
            S_SCAN_A: state_next = S_SCAN_B;
            S_SCAN_B: state_next = S_SCAN_C;
            S_SCAN_C: state_next = S_SCAN_D;
            S_SCAN_D:
            begin
                if (steps_reg == CNT_W'(1))
                begin
                    state_next = S_APPEND;
                end
                else
                begin
                    state_next = match ? S_SHIFT_REST : S_SCAN_A;
                end
            end
            S_SHIFT_REST:
            begin
                if (steps_reg == CNT_W'(1))
                begin
                    state_next = S_APPEND;
                end
            end
            S_APPEND: state_next = S_FINISH;
            S_FINISH:
            begin
                if (!fend_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = (cnt_reg == '0) ? S_EMIT_NONE : S_EMIT_LIST;
                end
            end
            S_EMIT_LIST:
            begin
                if (out_free && cnt_reg == CNT_W'(1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT_NONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control outputs of the sequencer
    always_comb
    begin
        div_start   = (state_reg == S_NORM_GO);
        rotate_en   = ((state_reg == S_SCAN_D) && !(match && higher))
                      || (state_reg == S_SHIFT_REST);
        drop_en     = (state_reg == S_SCAN_D) && match && higher;
        append_en   = (state_reg == S_APPEND) && !disc_reg && (cnt_reg < MAX_CNT);
        pop_en      = (state_reg == S_EMIT_LIST) && out_free;

        cnt_next    = cnt_reg;
        if (drop_en || pop_en)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
        else if (append_en)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end

        steps_next  = steps_reg;
        corner_next = corner_reg;
        disc_next   = disc_reg;
        ovf_next    = ovf_reg;

        if (in_acc)
        begin
            corner_next = 2'd0;
            disc_next   = 1'b0;
        end
        if ((state_reg == S_NORM_WAIT) && div_done)
        begin
            corner_next = corner_reg + 2'd1;
            steps_next  = cnt_reg;
        end
        if ((state_reg == S_SCAN_D) || (state_reg == S_SHIFT_REST))
        begin
            steps_next = steps_reg - CNT_W'(1);
        end
        if ((state_reg == S_SCAN_D) && match && !higher)
        begin
            disc_next = 1'b1;
        end
        if ((state_reg == S_APPEND) && !disc_reg && (cnt_reg == MAX_CNT))
        begin
            ovf_next = 1'b1;
        end
        if (((state_reg == S_EMIT_LIST) && out_free && (cnt_reg == CNT_W'(1)))
            || ((state_reg == S_EMIT_NONE) && out_free))
        begin
            ovf_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            steps_reg     <= '0;
            ovf_reg       <= 1'b0;
            disc_reg      <= 1'b0;
            corner_reg    <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            steps_reg  <= steps_next;
            ovf_reg    <= ovf_next;
            disc_reg   <= disc_next;
            corner_reg <= corner_next;
            if (pop_en || ((state_reg == S_EMIT_NONE) && out_free))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // candidate capture and corner results
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            dist_reg[0]    <= dl[15:0];
            dist_reg[1]    <= dt[15:0];
            dist_reg[2]    <= dr[15:0];
            dist_reg[3]    <= db[15:0];
            cand_score_reg <= cand_score;
            cand_key_reg   <= (cand_class < labeled_reg) ? cand_class : SHARED_CLASS;
            fend_reg       <= frame_end;
        end
        if ((state_reg == S_NORM_WAIT) && div_done)
        begin
            cand_box_reg[corner_reg] <= div_quo;
        end
    end

    // result beat register
    always_ff @(posedge clk)
    begin
        if (pop_en)
        begin
            out_entry_reg  <= cells[0];
            out_bvalid_reg <= 1'b1;
            out_ovf_reg    <= ovf_reg;
            out_last_reg   <= (cnt_reg == CNT_W'(1));
        end
        else if ((state_reg == S_EMIT_NONE) && out_free)
        begin
            out_entry_reg  <= '0;
            out_bvalid_reg <= 1'b0;
            out_ovf_reg    <= ovf_reg;
            out_last_reg   <= 1'b1;
        end
    end

    assign out_valid     = out_valid_reg;
    assign box_left      = out_entry_reg.corners[0];
    assign box_top       = out_entry_reg.corners[1];
    assign box_right     = out_entry_reg.corners[2];
    assign box_bottom    = out_entry_reg.corners[3];
    assign box_score     = out_entry_reg.score;
    assign box_class     = out_entry_reg.cls;
    assign box_valid     = out_bvalid_reg;
    assign list_overflow = out_ovf_reg;
    assign last_box      = out_last_reg;

    // list never holds more than its capacity
    `DFN_ASSERT(a_cnt_bound, cnt_reg <= MAX_CNT, "kept count above capacity")
    // list emission only starts with entries present
    `DFN_ASSERT(a_emit_nonempty, (state_reg != S_EMIT_LIST) || (cnt_reg != '0),
        "list emission with empty list")
    // a granted append grows the list by one
    `DFN_ASSERT_NEXT(a_append_grow, append_en, cnt_reg == $past(cnt_reg) + CNT_W'(1),
        "append did not grow the list")

endmodule
`default_nettype wire

// ----- hdl/dfn_div.sv -----
// radix-2 restoring divider for (d << 15) / ext with d <= ext
`default_nettype none
module dfn_div
    import dfn_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [15:0] num,
    input  wire logic [15:0] den,
    output logic [15:0]      quo,
    output logic             done
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [3:0]  step_reg, step_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] quo_reg, quo_next;
    logic        bit_reg, bit_next;
    logic [15:0] den_reg;
    logic [16:0] trial;

    // remainder shifted in with the next dividend bit
    assign trial = {rem_reg, bit_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        bit_next  = bit_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = 4'd0;
            rem_next  = {1'b0, num[15:1]};
            bit_next  = num[0];
        end
        else if (busy_reg)
        begin
            bit_next = 1'b0;
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = 16'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[14:0], 1'b1};
            end
            else
            begin
                rem_next = trial[15:0];
                quo_next = {quo_reg[14:0], 1'b0};
            end
            step_next = step_reg + 4'd1;
            if (step_reg == 4'd15)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 4'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        bit_reg <= bit_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

// ----- hdl/dfn_iou.sv -----
// three-stage overlap test of two boxes against the iou threshold
`default_nettype none
module dfn_iou
    import dfn_pkg::*;
(
    input  wire logic        clk,
    input  wire corners_t    box_a,
    input  wire corners_t    box_b,
    input  wire logic [15:0] thr,
    output logic             hit
);

    logic [15:0] near_x, near_y, far_x, far_y;
    logic signed [16:0] w_comb, h_comb;
    logic signed [16:0] w_reg, h_reg, aw_reg, ah_reg, bw_reg, bh_reg;
    logic signed [33:0] inter_reg, aa_reg, ab_reg;
    logic               pos_reg;
    logic [31:0]        uni_reg;
    logic [30:0]        inter3_reg;
    logic               pos3_reg;
    logic signed [34:0] uni_sum;
    logic [47:0]        lhs, rhs;

    always_comb
    begin
        near_x = (box_a[0] > box_b[0]) ? box_a[0] : box_b[0];
        near_y = (box_a[1] > box_b[1]) ? box_a[1] : box_b[1];
        far_x  = (box_a[2] < box_b[2]) ? box_a[2] : box_b[2];
        far_y  = (box_a[3] < box_b[3]) ? box_a[3] : box_b[3];
        w_comb = $signed({1'b0, far_x}) - $signed({1'b0, near_x});
        h_comb = $signed({1'b0, far_y}) - $signed({1'b0, near_y});
    end

    // stage 1: edge differences
    always_ff @(posedge clk)
    begin
        w_reg  <= w_comb;
        h_reg  <= h_comb;
        aw_reg <= $signed({1'b0, box_a[2]}) - $signed({1'b0, box_a[0]});
        ah_reg <= $signed({1'b0, box_a[3]}) - $signed({1'b0, box_a[1]});
        bw_reg <= $signed({1'b0, box_b[2]}) - $signed({1'b0, box_b[0]});
        bh_reg <= $signed({1'b0, box_b[3]}) - $signed({1'b0, box_b[1]});
    end

    // stage 2: intersection and areas
    always_ff @(posedge clk)
    begin
        inter_reg <= w_reg * h_reg;
        aa_reg    <= aw_reg * ah_reg;
        ab_reg    <= bw_reg * bh_reg;
        pos_reg   <= (w_reg > 17'sd0) && (h_reg > 17'sd0);
    end

    // stage 3: union; both areas are positive whenever the boxes intersect
    assign uni_sum = 35'(aa_reg) + 35'(ab_reg) - 35'(inter_reg);

    always_ff @(posedge clk)
    begin
        uni_reg    <= uni_sum[31:0];
        inter3_reg <= inter_reg[30:0];
        pos3_reg   <= pos_reg;
    end

    assign lhs = {1'b0, inter3_reg, 16'd0};
    assign rhs = thr * uni_reg;
    assign hit = pos3_reg && (lhs > rhs);

endmodule
`default_nettype wire

// ----- hdl/dfn_cell.sv -----
// one slot of the kept list, shifting toward the head
`default_nettype none
module dfn_cell
    import dfn_pkg::*;
(
    input  wire logic       clk,
    input  wire cell_ctrl_t ctrl,
    input  wire entry_t     nbr,
    input  wire entry_t     tail,
    output entry_t          q
);

    entry_t q_reg, q_next;

    always_comb
    begin
        q_next = q_reg;
        if (ctrl.load)
        begin
            q_next = tail;
        end
        else if (ctrl.shift)
        begin
            q_next = nbr;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule
`default_nettype wire

// ----- tb/detection_filter_greedy_nms_core_tb.sv -----
// self-checking testbench for the greedy nms detection filter core
`timescale 1ns / 1ps
`default_nettype none
module detection_filter_greedy_nms_core_tb;
    import dfn_pkg::*;

    typedef struct packed {
        logic [15:0] left;
        logic [15:0] top;
        logic [15:0] right;
        logic [15:0] bottom;
        logic [15:0] score;
        logic [7:0]  cls;
        logic        fend;
    } cand_t;

    typedef struct packed {
        logic [15:0] left;
        logic [15:0] top;
        logic [15:0] right;
        logic [15:0] bottom;
        logic [15:0] score;
        logic [7:0]  cls;
        logic        valid;
        logic        ovf;
        logic        last;
    } box_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [15:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic [15:0] cand_left, cand_top, cand_right, cand_bottom, cand_score;
    logic [7:0] cand_class;
    logic frame_end;
    logic out_valid;
    logic out_stall;
    logic [15:0] box_left, box_top, box_right, box_bottom, box_score;
    logic [7:0] box_class;
    logic box_valid, list_overflow, last_box;

    detection_filter_greedy_nms_core u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .cand_left(cand_left), .cand_top(cand_top), .cand_right(cand_right),
        .cand_bottom(cand_bottom), .cand_score(cand_score), .cand_class(cand_class),
        .frame_end(frame_end),
        .out_valid(out_valid), .out_stall(out_stall),
        .box_left(box_left), .box_top(box_top), .box_right(box_right),
        .box_bottom(box_bottom), .box_score(box_score), .box_class(box_class),
        .box_valid(box_valid), .list_overflow(list_overflow), .last_box(last_box)
    );

    // predictor copy of the registers
    logic [15:0] thr_score, thr_overlap, reg_x, reg_y, reg_w, reg_h;
    logic [7:0]  n_labeled;
    // predictor copy of the kept list
    entry_t kept_list [MAX_KEPT];
    int          kept_n;
    logic        ovf_flag;

    cand_t pending_cands[$];
    box_t  expected_boxes[$];
    int    fail_count = 0;
    bit    sender_hold = 0;

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial begin
        #300ms;
        $display("detection_filter_greedy_nms_core regression: fail");
        $finish;
    end

    // one corner into Q1.15, ok low when outside the region
    function automatic logic [16:0] norm_corner(logic [15:0] c, logic [15:0] off,
                                                logic [15:0] ext);
        int d;
        logic [31:0] q;
        d = $signed(c) - int'(off);
        if (ext == 0 || d < 0 || d > int'(ext)) return 17'd0;
        q = (32'(d) << 15) / 32'(ext);
        return {1'b1, q[15:0]};
    endfunction

    function automatic bit boxes_overlap(corners_t a, corners_t b);
        longint w, h, inter, uni;
        longint al, at, ar, ab, bl, bt, br, bb;
        al = a[0]; at = a[1]; ar = a[2]; ab = a[3];
        bl = b[0]; bt = b[1]; br = b[2]; bb = b[3];
        w = (ar < br ? ar : br) - (al > bl ? al : bl);
        if (w <= 0) return 0;
        h = (ab < bb ? ab : bb) - (at > bt ? at : bt);
        if (h <= 0) return 0;
        inter = w * h;
        uni = (ar - al) * (ab - at) + (br - bl) * (bb - bt) - inter;
        return inter * 65536 > longint'(thr_overlap) * uni;
    endfunction

    // runs the suppression on one candidate and queues any frame output
    task automatic filter_candidate(cand_t c);
        logic [16:0] nl, nt, nr, nb;
        corners_t cb;
        logic [7:0] key;
        bit discard;
        int hit;
        box_t bx;
        discard = 0;
        hit = -1;
        nl = norm_corner(c.left, reg_x, reg_w);
        nt = norm_corner(c.top, reg_y, reg_h);
        nr = norm_corner(c.right, reg_x, reg_w);
        nb = norm_corner(c.bottom, reg_y, reg_h);
        if (c.score >= thr_score && nl[16] && nt[16] && nr[16] && nb[16]) begin
            cb[0] = nl[15:0]; cb[1] = nt[15:0]; cb[2] = nr[15:0]; cb[3] = nb[15:0];
            key = (c.cls < n_labeled) ? c.cls : SHARED_CLASS;
            for (int i = 0; i < kept_n; i++)
                if (hit < 0 && kept_list[i].cls == key && boxes_overlap(cb, kept_list[i].corners))
                    hit = i;
            if (hit >= 0) begin
                if (c.score > kept_list[hit].score) begin
                    for (int j = hit; j + 1 < kept_n; j++) kept_list[j] = kept_list[j + 1];
                    kept_n--;
                end
                else discard = 1;
            end
            if (!discard) begin
                if (kept_n < MAX_KEPT) begin
                    kept_list[kept_n] = '{corners: cb, score: c.score, cls: key};
                    kept_n++;
                end
                else ovf_flag = 1;
            end
        end
        if (c.fend) begin
            if (kept_n == 0) begin
                bx = '0;
                bx.ovf = ovf_flag;
                bx.last = 1;
                expected_boxes.push_back(bx);
            end
            for (int k = 0; k < kept_n; k++) begin
                bx.left = kept_list[k].corners[0];
                bx.top = kept_list[k].corners[1];
                bx.right = kept_list[k].corners[2];
                bx.bottom = kept_list[k].corners[3];
                bx.score = kept_list[k].score;
                bx.cls = kept_list[k].cls;
                bx.valid = 1;
                bx.ovf = ovf_flag;
                bx.last = (k + 1 == kept_n);
                expected_boxes.push_back(bx);
            end
            kept_n = 0;
            ovf_flag = 0;
        end
    endtask

    // driver: one beat per queued candidate, sometimes with a random gap after a taken beat
    int send_gap = 0;
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 0;
            send_gap <= 0;
        end
        else begin
            if (in_valid && !in_stall) begin
                filter_candidate(pending_cands.pop_front());
            end
            if (in_valid && in_stall) begin
                // hold the stalled beat
            end
            else if (send_gap > 0) begin
                in_valid <= 0;
                send_gap <= send_gap - 1;
            end
            else if (pending_cands.size() > 0 && !sender_hold && !cfg_we
                     && (!in_valid || in_stall || pending_cands.size() > 0)) begin
                // a beat was just taken; draw the gap for the next one
                if (in_valid && !in_stall && $urandom_range(0, 1)) begin
                    in_valid <= 0;
                    send_gap <= $urandom_range(0, 13);
                end
                else begin
                    in_valid <= 1;
                    cand_left <= pending_cands[0].left;
                    cand_top <= pending_cands[0].top;
                    cand_right <= pending_cands[0].right;
                    cand_bottom <= pending_cands[0].bottom;
                    cand_score <= pending_cands[0].score;
                    cand_class <= pending_cands[0].cls;
                    frame_end <= pending_cands[0].fend;
                end
            end
            else in_valid <= 0;
        end
    end

    // monitor: random stall per beat and a field by field check
    int stall_left = 0;
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall <= 0;
            stall_left <= 0;
        end
        else begin
            if (out_valid && !out_stall) begin
                if (expected_boxes.size() == 0) begin
                    $error("unexpected result beat");
                    fail_count++;
                end
                else begin
                    box_t e;
                    e = expected_boxes.pop_front();
                    if (box_left !== e.left) begin
                        $error("box_left exp %0d got %0d", e.left, box_left); fail_count++;
                    end
                    if (box_top !== e.top) begin
                        $error("box_top exp %0d got %0d", e.top, box_top); fail_count++;
                    end
                    if (box_right !== e.right) begin
                        $error("box_right exp %0d got %0d", e.right, box_right); fail_count++;
                    end
                    if (box_bottom !== e.bottom) begin
                        $error("box_bottom exp %0d got %0d", e.bottom, box_bottom);
                        fail_count++;
                    end
                    if (box_score !== e.score) begin
                        $error("box_score exp %0d got %0d", e.score, box_score); fail_count++;
                    end
                    if (box_class !== e.cls) begin
                        $error("box_class exp %0d got %0d", e.cls, box_class); fail_count++;
                    end
                    if (box_valid !== e.valid) begin
                        $error("box_valid exp %0d got %0d", e.valid, box_valid); fail_count++;
                    end
                    if (list_overflow !== e.ovf) begin
                        $error("list_overflow exp %0d got %0d", e.ovf, list_overflow);
                        fail_count++;
                    end
                    if (last_box !== e.last) begin
                        $error("last_box exp %0d got %0d", e.last, last_box); fail_count++;
                    end
                end
                stall_left <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 13);
                out_stall <= 0;
            end
            else if (stall_left > 0) begin
                out_stall <= 1;
                stall_left <= stall_left - 1;
            end
            else out_stall <= 0;
        end
    end

    // wait for the list to drain and the core to settle
    task automatic wait_idle();
        while (pending_cands.size() > 0 || in_valid || expected_boxes.size() > 0)
            @(posedge clk);
        repeat (250) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
        case (idx)
            CFG_SCORE_THR:   thr_score = val;
            CFG_OVERLAP_THR: thr_overlap = val;
            CFG_REGION_X:    reg_x = val;
            CFG_REGION_Y:    reg_y = val;
            CFG_REGION_W:    reg_w = val;
            CFG_REGION_H:    reg_h = val;
            CFG_LABELED:     n_labeled = val[7:0];
            default: ;
        endcase
    endtask

    task automatic push_cand(logic [15:0] l, logic [15:0] t, logic [15:0] r,
                             logic [15:0] b, logic [15:0] s, logic [7:0] c, logic f);
        pending_cands.push_back('{left: l, top: t, right: r, bottom: b, score: s,
                                  cls: c, fend: f});
    endtask

    // boxes mostly inside the region, with some corners past it, some inverted and some random
    task automatic push_random(int frame_len);
        int span_x, span_y, x0, y0, w, h;
        logic [15:0] s;
        logic [7:0] c;
        span_x = int'(reg_w); span_y = int'(reg_h);
        for (int i = 0; i < frame_len; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                push_cand(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom), 8'($urandom), i == frame_len - 1);
                continue;
            end
            x0 = int'(reg_x) + int'($urandom_range(0, span_x));
            y0 = int'(reg_y) + int'($urandom_range(0, span_y));
            w = int'($urandom_range(0, span_x / 3 + 1));
            h = int'($urandom_range(0, span_y / 3 + 1));
            if ($urandom_range(0, 7) == 0) w = -w;
            s = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(thr_score, 65535));
            c = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 3));
            push_cand(16'(x0), 16'(y0), 16'(x0 + w), 16'(y0 + h), s, c, i == frame_len - 1);
        end
    endtask

    int n_items;

    initial begin
        rst_n = 0;
        cfg_we = 0; cfg_index = CFG_SCORE_THR; cfg_data = 0;
        in_valid = 0; out_stall = 0;
        cand_left = 0; cand_top = 0; cand_right = 0; cand_bottom = 0;
        cand_score = 0; cand_class = 0; frame_end = 0;
        thr_score = 45875; thr_overlap = 32768; reg_x = 0; reg_y = 0;
        reg_w = 10240; reg_h = 10240; n_labeled = 80;
        kept_n = 0; ovf_flag = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: empty frame, extremes, replace, equal score, inverted, shared class
        push_cand(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'hffff, 0, 1);
        push_cand(0, 0, 10240, 10240, 16'hffff, 0, 0);
        push_cand(0, 0, 10240, 10240, 16'hffff, 0, 0);
        push_cand(16, 16, 10200, 10200, 16'hfff0, 0, 0);
        push_cand(100, 100, 2000, 2000, 50000, 3, 0);
        push_cand(110, 110, 2010, 2010, 60000, 3, 0);
        push_cand(5000, 5000, 4000, 4000, 60000, 3, 0);
        push_cand(3000, 3000, 4000, 4000, 50000, 200, 0);
        push_cand(3000, 3000, 4000, 4000, 55000, 255, 0);
        push_cand(0, 0, 100, 100, 45874, 1, 0);
        push_cand(0, 0, 100, 100, 45875, 79, 1);
        wait_idle();

        // full list: 34 disjoint boxes, then a replacement
        write_reg(CFG_SCORE_THR, 0);
        for (int i = 0; i < 34; i++)
            push_cand(16'(i * 256), 0, 16'(i * 256 + 100), 100, 1000, 7, 0);
        push_cand(0, 0, 100, 100, 2000, 7, 1);
        wait_idle();

        // zero extents and extreme registers
        write_reg(CFG_REGION_W, 0);
        push_cand(0, 0, 0, 0, 16'hffff, 1, 1);
        wait_idle();
        write_reg(CFG_REGION_W, 16'hffff);
        write_reg(CFG_REGION_H, 0);
        push_cand(0, 0, 0, 0, 16'hffff, 1, 1);
        wait_idle();
        write_reg(CFG_REGION_H, 16'hffff);
        write_reg(CFG_OVERLAP_THR, 0);
        write_reg(CFG_LABELED, 0);
        push_cand(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff, 8'hff, 0);
        push_cand(0, 0, 16'h7fff, 16'h7fff, 16'hffff, 8'h0, 1);
        wait_idle();

        // random phases across several settings
        n_items = 0;
        for (int ph = 0; n_items < 400; ph++) begin
            write_reg(CFG_SCORE_THR, ph % 3 == 0 ? 16'hffff : 16'($urandom_range(0, 50000)));
            write_reg(CFG_OVERLAP_THR, ph % 4 == 1 ? 16'hffff : 16'($urandom));
            write_reg(CFG_REGION_X, ph % 5 == 2 ? 16'hffff : 16'($urandom_range(0, 4000)));
            write_reg(CFG_REGION_Y, 16'($urandom_range(0, 4000)));
            write_reg(CFG_REGION_W, 16'($urandom_range(16, 16000)));
            write_reg(CFG_REGION_H, ph % 6 == 3 ? 16'd16 : 16'($urandom_range(16, 16000)));
            write_reg(CFG_LABELED, ph % 4 == 0 ? 8'hff : 8'($urandom_range(0, 4)));
            for (int f = 0; f < 4; f++) begin
                int len;
                len = $urandom_range(1, 15);
                push_random(len);
                n_items += len;
                if (f == 1) begin
                    // sender holds until the core has drained
                    while (pending_cands.size() > 0 || in_valid) @(posedge clk);
                    sender_hold = 1;
                    while (expected_boxes.size() > 0) @(posedge clk);
                    sender_hold = 0;
                end
            end
            wait_idle();
        end

        if (fail_count == 0)
            $display("detection_filter_greedy_nms_core regression: pass");
        else
            $display("detection_filter_greedy_nms_core regression: fail");
        $finish;
    end
endmodule
`default_nettype wire
